### rtl/clt_pkg.sv
// Shared types, character codes and helpers for the character LCD text layout block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package clt_pkg;

   // default geometry of the display
   localparam int LINE_LENGTH_DEF = 20;
   localparam int LINE_COUNT_DEF  = 4;

   // text codes with special meaning
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // set-address instruction
   localparam logic [7:0] SET_ADDR  = 8'h80;
   localparam logic [7:0] ADDR_MASK = 8'h7F;

   // widest repeat count that fits the field
   localparam logic [4:0] REPEAT_MAX = 5'd31;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WRITE = 2'd1,
      PH_CLIP  = 2'd2,
      PH_DRAIN = 2'd3
   } phase_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_value;
      logic [4:0] repeat_count;
      logic       last_of_run;
   } entry_type;

   function automatic logic [7:0] line_base(input logic [1:0] line);
      logic [7:0] base;
      begin
         case (line)
            2'd0: base = 8'h00;
            2'd1: base = 8'h40;
            2'd2: base = 8'h14;
            2'd3: base = 8'h54;
            default: base = 8'h00;
         endcase
         return base;
      end
   endfunction

   function automatic entry_type addr_entry(input logic [1:0] line);
      entry_type e;
      begin
         e.is_data      = 1'b0;
         e.bus_value    = SET_ADDR | (line_base(line) & ADDR_MASK);
         e.repeat_count = 5'd1;
         e.last_of_run  = 1'b0;
         return e;
      end
   endfunction

   function automatic entry_type pad_entry(input logic [4:0] count);
      entry_type e;
      begin
         e.is_data      = 1'b1;
         e.bus_value    = CHAR_SPACE;
         e.repeat_count = count;
         e.last_of_run  = 1'b0;
         return e;
      end
   endfunction

endpackage

### rtl/clt_layout.sv
// Layout state (phase, line, column) and the per-byte command list decode.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_layout
   import clt_pkg::*;
#(
   parameter int LINE_LENGTH = LINE_LENGTH_DEF,
   parameter int LINE_COUNT  = LINE_COUNT_DEF,
   parameter int MAX_RES     = 1 + 2 * LINE_COUNT,
   parameter int CNT_W       = $clog2(MAX_RES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [7:0]                    text_byte,
   output entry_type [MAX_RES-1:0]       list_out,
   output logic [CNT_W-1:0]              list_cnt
);

   localparam int COL_W  = $clog2(LINE_LENGTH + 1);
   localparam int BODY_N = 2 * LINE_COUNT;

   phase_type        phase_ff, phase_in, eff_phase;
   logic [1:0]       line_ff, line_in, eff_line;
   logic [COL_W-1:0] col_ff, col_in, eff_col, col_inc;
   logic             open_str;
   logic [2:0]       line_next3;
   logic             past_last;
   logic             wrap;
   logic [2:0]       nlines;
   logic [5:0]       pad_diff;
   logic [4:0]       pad_first, pad_full;
   entry_type        body [BODY_N];
   logic [CNT_W-1:0] body_cnt;

   // state as seen by this byte: an idle block opens a new string at line 0
   always_comb begin
      open_str  = (phase_ff == PH_IDLE);
      eff_phase = open_str ? PH_WRITE : phase_ff;
      eff_line  = open_str ? 2'd0 : line_ff;
      eff_col   = open_str ? '0 : col_ff;
      line_next3 = {1'b0, eff_line} + 3'd1;
      past_last  = (line_next3 >= 3'(LINE_COUNT));
      col_inc    = eff_col + COL_W'(1);
      wrap       = (col_inc >= COL_W'(LINE_LENGTH));
      nlines     = 3'(LINE_COUNT) - {1'b0, eff_line};
      pad_diff   = 6'(LINE_LENGTH) - 6'(eff_col);
      pad_first  = (pad_diff > 6'(REPEAT_MAX)) ? REPEAT_MAX : pad_diff[4:0];
      pad_full   = (6'(LINE_LENGTH) > 6'(REPEAT_MAX)) ? REPEAT_MAX : 5'(LINE_LENGTH);
   end

   // next state
   always_comb begin
      phase_in = eff_phase;
      line_in  = eff_line;
      col_in   = eff_col;
      case (eff_phase)
         PH_WRITE: begin
            if (text_byte == CHAR_NUL) begin
               phase_in = PH_IDLE;
               line_in  = 2'd0;
               col_in   = '0;
            end else if (text_byte == CHAR_LF) begin
               line_in  = line_next3[1:0];
               col_in   = '0;
               phase_in = past_last ? PH_DRAIN : PH_WRITE;
            end else if (text_byte != CHAR_CR) begin
               if (wrap) begin
                  line_in  = line_next3[1:0];
                  col_in   = '0;
                  phase_in = past_last ? PH_DRAIN : PH_CLIP;
               end else begin
                  col_in = col_inc;
               end
            end
         end
         PH_CLIP: begin
            if (text_byte == CHAR_NUL) begin
               phase_in = PH_IDLE;
               line_in  = 2'd0;
               col_in   = '0;
            end else if (text_byte == CHAR_LF) begin
               phase_in = PH_WRITE;
            end
         end
         PH_DRAIN: begin
            if (text_byte == CHAR_NUL) begin
               phase_in = PH_IDLE;
               line_in  = 2'd0;
               col_in   = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // command list body, before the opening address
   always_comb begin
      for (int i = 0; i < BODY_N; i++) begin
         body[i] = '0;
      end
      body_cnt = '0;
      case (eff_phase)
         PH_WRITE, PH_CLIP: begin
            if (text_byte == CHAR_NUL) begin
               // pad the rest of this line and every line below it
               for (int k = 0; k < LINE_COUNT; k++) begin
                  if (3'(k) < nlines) begin
                     body[2*k]   = pad_entry((k == 0) ? pad_first : pad_full);
                     body[2*k+1] = addr_entry(eff_line + 2'(k + 1));
                  end
               end
               body_cnt = CNT_W'({nlines, 1'b0});
            end else if (eff_phase == PH_WRITE && text_byte == CHAR_LF) begin
               body[0]  = pad_entry(pad_first);
               body[1]  = addr_entry(line_next3[1:0]);
               body_cnt = CNT_W'(2);
            end else if (eff_phase == PH_WRITE && text_byte != CHAR_CR) begin
               body[0].is_data      = 1'b1;
               body[0].bus_value    = text_byte;
               body[0].repeat_count = 5'd1;
               if (wrap) begin
                  body[1]  = addr_entry(line_next3[1:0]);
                  body_cnt = CNT_W'(2);
               end else begin
                  body_cnt = CNT_W'(1);
               end
            end
         end
         default: begin
            body_cnt = '0;
         end
      endcase
   end

   // final list: optional opening address, then the body; mark the last word
   always_comb begin
      list_cnt    = body_cnt + CNT_W'(open_str);
      list_out[0] = open_str ? addr_entry(2'd0) : body[0];
      for (int i = 1; i < BODY_N; i++) begin
         list_out[i] = open_str ? body[i-1] : body[i];
      end
      list_out[MAX_RES-1] = open_str ? body[BODY_N-1] : '0;
      for (int i = 0; i < MAX_RES; i++) begin
         list_out[i].last_of_run = (CNT_W'(i + 1) == list_cnt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         line_ff  <= 2'd0;
         col_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
      end
   end

   a_clip_col_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLIP |-> col_ff == '0)
      else $error("clip phase with nonzero column");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WRITE |->
         (col_ff < COL_W'(LINE_LENGTH)) && ({1'b0, line_ff} < 3'(LINE_COUNT)))
      else $error("write position outside the display");

   a_open_gives_words: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_IDLE |-> list_cnt != '0)
      else $error("new string produced no words");

endmodule

### rtl/clt_drain.sv
// Result buffer: holds one byte's command list and hands it out one word a cycle while out_stall is low.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_drain
   import clt_pkg::*;
#(
   parameter int MAX_RES = 1 + 2 * LINE_COUNT_DEF,
   parameter int CNT_W   = $clog2(MAX_RES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  entry_type [MAX_RES-1:0] list_in,
   input  logic [CNT_W-1:0]        list_cnt,
   output logic                    ready,
   output logic                    out_valid,
   input  logic                    out_stall,
   output entry_type               out_word
);

   entry_type [MAX_RES-1:0] list_ff, list_nx_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    take_out;

   assign out_valid = (cnt_ff != '0);
   assign take_out  = out_valid && !out_stall;
   assign ready     = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && !out_stall);
   assign out_word  = list_ff[0];

   always_comb begin
      list_nx_in = list_ff;
      cnt_in     = cnt_ff;
      if (load) begin
         list_nx_in = list_in;
         cnt_in     = list_cnt;
      end else if (take_out) begin
         for (int i = 0; i < MAX_RES - 1; i++) begin
            list_nx_in[i] = list_ff[i+1];
         end
         list_nx_in[MAX_RES-1] = '0;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_nx_in;
   end

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == CNT_W'(1) |-> list_ff[0].last_of_run)
      else $error("final word of a run not marked");

   a_last_only_at_end: assert property (@(posedge clock) disable iff (reset)
      cnt_ff > CNT_W'(1) |-> !list_ff[0].last_of_run)
      else $error("run marked ended too early");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RES))
      else $error("buffer count exceeds depth");

endmodule

### rtl/char_lcd_text_layout.sv
// Character LCD text layout, top level: text bytes in, LCD write commands out.
// The first command word is offered in the cycle after the text byte is taken.
// Throughput: one word per cycle while rsp_stall is low; a byte yields 0 to
// 1 + 2 * LINE_COUNT words.
// Reset (synchronous, active high): layout returns to idle at line 0, column 0,
// and the result buffer empties.
`timescale 1ns / 1ps

module char_lcd_text_layout
   import clt_pkg::*;
#(
   parameter int LINE_LENGTH = LINE_LENGTH_DEF,
   parameter int LINE_COUNT  = LINE_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // text input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   // command output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_data,
   output logic [7:0] rsp_bus_value,
   output logic [4:0] rsp_repeat_count,
   output logic       rsp_last_of_run
);

   // worst case: opening address, then pad and address for every line
   localparam int MAX_RES = 1 + 2 * LINE_COUNT;
   localparam int CNT_W   = $clog2(MAX_RES + 1);

   entry_type [MAX_RES-1:0] list;
   logic [CNT_W-1:0]        list_cnt;
   logic                    buf_ready;
   logic                    req_take;
   entry_type               word;

   // take a byte whenever the buffer is empty or its final word leaves this cycle
   assign req_stall = !buf_ready;
   assign req_take  = req_valid && buf_ready;

   // decode the byte against the current layout state into a list of words
   clt_layout #(
      .LINE_LENGTH (LINE_LENGTH),
      .LINE_COUNT  (LINE_COUNT),
      .MAX_RES     (MAX_RES),
      .CNT_W       (CNT_W)
   ) u_layout (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .text_byte (req_text_byte),
      .list_out  (list),
      .list_cnt  (list_cnt)
   );

   // hold the list and drain it one word a cycle while rsp_stall is low
   clt_drain #(
      .MAX_RES (MAX_RES),
      .CNT_W   (CNT_W)
   ) u_drain (
      .clock     (clock),
      .reset     (reset),
      .load      (req_take),
      .list_in   (list),
      .list_cnt  (list_cnt),
      .ready     (buf_ready),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (word)
   );

   assign rsp_is_data      = word.is_data;
   assign rsp_bus_value    = word.bus_value;
   assign rsp_repeat_count = word.repeat_count;
   assign rsp_last_of_run  = word.last_of_run;

endmodule
